### hdl/assert_macros.svh
// Assertion macros shared by the triangle pair edge intersection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/tpei_pkg.sv
// ----------------------------------------------------------------------------
// tpei_pkg
// Shared constants for the triangle pair edge intersection block.
// ----------------------------------------------------------------------------
package tpei_pkg;
  localparam int NUM_PAIRS = 9;
  localparam int PAIR_BITS = 4;
  localparam logic [PAIR_BITS-1:0] PAIR_NONE = 4'd0;
endpackage

### hdl/tpei_edge_unit.sv
// ----------------------------------------------------------------------------
// tpei_edge_unit
// Pipelined test of one edge pair: determinant, range checks and the
// crossing point by a restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tpei_edge_unit #(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] ax,
  input  logic signed [CW-1:0] ay,
  input  logic signed [CW-1:0] bx,
  input  logic signed [CW-1:0] by,
  input  logic signed [CW-1:0] cx,
  input  logic signed [CW-1:0] cy,
  input  logic signed [CW-1:0] dx,
  input  logic signed [CW-1:0] dy,
  output logic                 out_valid,
  output logic                 crossing,
  output logic signed [CW-1:0] px,
  output logic signed [CW-1:0] py
);
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;
  localparam int QW = CW + 1;
  localparam int NS = QW;

  logic signed [DW-1:0] s1_bax, s1_bay, s1_cdx, s1_cdy, s1_cax, s1_cay;
  logic signed [CW-1:0] s1_ax, s1_ay;
  logic                 s1_v;

  always_ff @(posedge clk) begin
    s1_bax <= DW'(bx) - DW'(ax);
    s1_bay <= DW'(by) - DW'(ay);
    s1_cdx <= DW'(cx) - DW'(dx);
    s1_cdy <= DW'(cy) - DW'(dy);
    s1_cax <= DW'(cx) - DW'(ax);
    s1_cay <= DW'(cy) - DW'(ay);
    s1_ax <= ax;
    s1_ay <= ay;
    if (rst) s1_v <= 1'b0;
    else s1_v <= in_valid;
  end

  logic signed [PW-1:0] s2_p0, s2_p1, s2_p2, s2_p3, s2_p4, s2_p5;
  logic signed [DW-1:0] s2_bax, s2_bay;
  logic signed [CW-1:0] s2_ax, s2_ay;
  logic                 s2_v;

  always_ff @(posedge clk) begin
    s2_p0 <= PW'(s1_bax) * PW'(s1_cdy);
    s2_p1 <= PW'(s1_cdx) * PW'(s1_bay);
    s2_p2 <= PW'(s1_cax) * PW'(s1_cdy);
    s2_p3 <= PW'(s1_cdx) * PW'(s1_cay);
    s2_p4 <= PW'(s1_bax) * PW'(s1_cay);
    s2_p5 <= PW'(s1_cax) * PW'(s1_bay);
    s2_bax <= s1_bax;
    s2_bay <= s1_bay;
    s2_ax <= s1_ax;
    s2_ay <= s1_ay;
    if (rst) s2_v <= 1'b0;
    else s2_v <= s1_v;
  end

  logic signed [NW-1:0] det_w, tn_w, un_w;
  logic [NW-1:0]        det_a, tn_n, un_n;
  logic                 det_neg;
  logic                 ok_w;
  always_comb begin
    det_w = NW'(s2_p0) - NW'(s2_p1);
    tn_w  = NW'(s2_p2) - NW'(s2_p3);
    un_w  = NW'(s2_p4) - NW'(s2_p5);
    det_neg = det_w[NW-1];
    det_a = det_neg ? NW'(-det_w) : NW'(det_w);
    tn_n  = det_neg ? NW'(-tn_w) : NW'(tn_w);
    un_n  = det_neg ? NW'(-un_w) : NW'(un_w);
    ok_w = (det_w != '0) && !tn_n[NW-1] && !un_n[NW-1] &&
           (tn_n <= det_a) && (un_n <= det_a);
  end

  logic [NW-1:0]        s3_det, s3_tn;
  logic signed [DW-1:0] s3_bax, s3_bay;
  logic signed [CW-1:0] s3_ax, s3_ay;
  logic                 s3_ok, s3_v;

  always_ff @(posedge clk) begin
    s3_det <= det_a;
    s3_tn <= tn_n;
    s3_bax <= s2_bax;
    s3_bay <= s2_bay;
    s3_ax <= s2_ax;
    s3_ay <= s2_ay;
    s3_ok <= ok_w;
    if (rst) s3_v <= 1'b0;
    else s3_v <= s2_v;
  end

  localparam int MW = NW + DW;
  logic [MW-1:0]        s4_nx, s4_ny;
  logic [NW-1:0]        s4_det;
  logic                 s4_sx, s4_sy;
  logic signed [CW-1:0] s4_ax, s4_ay;
  logic                 s4_ok, s4_v;

  always_ff @(posedge clk) begin
    s4_nx <= MW'(s3_tn) * MW'(s3_bax[DW-1] ? DW'(-s3_bax) : DW'(s3_bax));
    s4_ny <= MW'(s3_tn) * MW'(s3_bay[DW-1] ? DW'(-s3_bay) : DW'(s3_bay));
    s4_sx <= s3_bax[DW-1];
    s4_sy <= s3_bay[DW-1];
    s4_det <= s3_det;
    s4_ax <= s3_ax;
    s4_ay <= s3_ay;
    s4_ok <= s3_ok;
    if (rst) s4_v <= 1'b0;
    else s4_v <= s3_v;
  end

  // Quotient lies below 2^QW; for a crossing, the final remainder stays below det.
  logic [MW-1:0]        dv_rx [NS+1];
  logic [MW-1:0]        dv_ry [NS+1];
  logic [QW-1:0]        dv_qx [NS+1];
  logic [QW-1:0]        dv_qy [NS+1];
  logic [NW-1:0]        dv_d  [NS+1];
  logic                 dv_sx [NS+1];
  logic                 dv_sy [NS+1];
  logic signed [CW-1:0] dv_ax [NS+1];
  logic signed [CW-1:0] dv_ay [NS+1];
  logic                 dv_ok [NS+1];
  logic                 dv_v  [NS+1];

  always_comb begin
    dv_rx[0] = s4_nx;
    dv_ry[0] = s4_ny;
    dv_qx[0] = '0;
    dv_qy[0] = '0;
    dv_d[0]  = s4_det;
    dv_sx[0] = s4_sx;
    dv_sy[0] = s4_sy;
    dv_ax[0] = s4_ax;
    dv_ay[0] = s4_ay;
    dv_ok[0] = s4_ok;
    dv_v[0]  = s4_v;
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    localparam int SH = NS - 1 - k;
    logic [MW+QW-1:0] trial;
    logic [MW+QW-1:0] rwx, rwy;
    logic             gex, gey;
    always_comb begin
      trial = (MW+QW)'(dv_d[k]) << SH;
      rwx = (MW+QW)'(dv_rx[k]);
      rwy = (MW+QW)'(dv_ry[k]);
      gex = rwx >= trial;
      gey = rwy >= trial;
    end
    always_ff @(posedge clk) begin
      dv_rx[k+1] <= gex ? MW'(rwx - trial) : dv_rx[k];
      dv_ry[k+1] <= gey ? MW'(rwy - trial) : dv_ry[k];
      dv_qx[k+1] <= dv_qx[k] | (QW'(gex) << SH);
      dv_qy[k+1] <= dv_qy[k] | (QW'(gey) << SH);
      dv_d[k+1]  <= dv_d[k];
      dv_sx[k+1] <= dv_sx[k];
      dv_sy[k+1] <= dv_sy[k];
      dv_ax[k+1] <= dv_ax[k];
      dv_ay[k+1] <= dv_ay[k];
      dv_ok[k+1] <= dv_ok[k];
      if (rst) dv_v[k+1] <= 1'b0;
      else dv_v[k+1] <= dv_v[k];
    end
  end

  logic signed [QW:0] rx, ry;
  always_comb begin
    rx = dv_sx[NS] ? ((QW+1)'(dv_ax[NS]) - (QW+1)'(dv_qx[NS]))
                   : ((QW+1)'(dv_ax[NS]) + (QW+1)'(dv_qx[NS]));
    ry = dv_sy[NS] ? ((QW+1)'(dv_ay[NS]) - (QW+1)'(dv_qy[NS]))
                   : ((QW+1)'(dv_ay[NS]) + (QW+1)'(dv_qy[NS]));
  end

  assign out_valid = dv_v[NS];
  assign crossing = dv_ok[NS];
  assign px = CW'(rx);
  assign py = CW'(ry);

  `ASSERT_NEXT(a_v1, clk, rst, in_valid, s1_v)
  `ASSERT_IMPL(a_det, clk, rst, s3_v && s3_ok, s3_det != '0)
  `ASSERT_IMPL(a_tn, clk, rst, s3_v && s3_ok, s3_tn <= s3_det)
endmodule

### hdl/triangle_pair_edge_intersection.sv
// ----------------------------------------------------------------------------
// triangle_pair_edge_intersection
// Tests every edge pair of two triangles in parallel pipelines and
// reports the first crossing in pair order.
//
//   channel | handshake     | payload
//   input   | start / busy  | first_*, second_* vertex coordinates
//   result  | done strobe   | hit, pair_index, hit_x, hit_y
//
// One transaction per cycle; each pair unit finds its crossing point with the
// restoring divider (one quotient bit per stage).
// busy is held low: the receiver cannot stall, so nothing ever waits.
// rst clears all valid bits synchronously.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module triangle_pair_edge_intersection #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] first_v1_x,
  input  logic signed [COORD_BITS-1:0] first_v1_y,
  input  logic signed [COORD_BITS-1:0] first_v2_x,
  input  logic signed [COORD_BITS-1:0] first_v2_y,
  input  logic signed [COORD_BITS-1:0] first_v3_x,
  input  logic signed [COORD_BITS-1:0] first_v3_y,
  input  logic signed [COORD_BITS-1:0] second_v1_x,
  input  logic signed [COORD_BITS-1:0] second_v1_y,
  input  logic signed [COORD_BITS-1:0] second_v2_x,
  input  logic signed [COORD_BITS-1:0] second_v2_y,
  input  logic signed [COORD_BITS-1:0] second_v3_x,
  input  logic signed [COORD_BITS-1:0] second_v3_y,
  output logic                         done,
  output logic                         hit,
  output logic [tpei_pkg::PAIR_BITS-1:0] pair_index,
  output logic signed [COORD_BITS-1:0] hit_x,
  output logic signed [COORD_BITS-1:0] hit_y
);
  localparam int CW = COORD_BITS + 0 * FRAC_BITS;
  localparam int NP = tpei_pkg::NUM_PAIRS;

  logic signed [CW-1:0] fx [3];
  logic signed [CW-1:0] fy [3];
  logic signed [CW-1:0] sx [3];
  logic signed [CW-1:0] sy [3];
  always_comb begin
    fx[0] = first_v1_x;  fy[0] = first_v1_y;
    fx[1] = first_v2_x;  fy[1] = first_v2_y;
    fx[2] = first_v3_x;  fy[2] = first_v3_y;
    sx[0] = second_v1_x; sy[0] = second_v1_y;
    sx[1] = second_v2_x; sy[1] = second_v2_y;
    sx[2] = second_v3_x; sy[2] = second_v3_y;
  end

  assign busy = 1'b0;

  logic                 u_v  [NP];
  logic                 u_c  [NP];
  logic signed [CW-1:0] u_px [NP];
  logic signed [CW-1:0] u_py [NP];

  for (genvar i = 0; i < 3; i++) begin : g_i
    for (genvar j = 0; j < 3; j++) begin : g_j
      tpei_edge_unit #(.CW(CW)) u_edge (
        .clk(clk), .rst(rst), .in_valid(start),
        .ax(fx[i]), .ay(fy[i]), .bx(fx[(i+1)%3]), .by(fy[(i+1)%3]),
        .cx(sx[j]), .cy(sy[j]), .dx(sx[(j+1)%3]), .dy(sy[(j+1)%3]),
        .out_valid(u_v[3*i+j]), .crossing(u_c[3*i+j]),
        .px(u_px[3*i+j]), .py(u_py[3*i+j])
      );
    end
  end

  logic                           sel_hit;
  logic [tpei_pkg::PAIR_BITS-1:0] sel_idx;
  logic signed [CW-1:0]           sel_x, sel_y;
  always_comb begin
    sel_hit = 1'b0;
    sel_idx = tpei_pkg::PAIR_NONE;
    sel_x = '0;
    sel_y = '0;
    for (int k = NP - 1; k >= 0; k--) begin
      if (u_c[k]) begin
        sel_hit = 1'b1;
        sel_idx = tpei_pkg::PAIR_BITS'(k);
        sel_x = u_px[k];
        sel_y = u_py[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    hit <= sel_hit;
    pair_index <= sel_idx;
    hit_x <= sel_x;
    hit_y <= sel_y;
    if (rst) done <= 1'b0;
    else done <= u_v[0];
  end

  `ASSERT_IMPL(a_miss, clk, rst, done && !hit,
               pair_index == tpei_pkg::PAIR_NONE && hit_x == '0 && hit_y == '0)
  `ASSERT_IMPL(a_idx, clk, rst, done, pair_index < 4'd9)
  `ASSERT_IMPL(a_sync, clk, rst, u_v[0], u_v[8] && u_v[4])
endmodule
